### hdl/npcm_pkg.sv
// Shared types and constants for the nearest palette color mapper.
// Used by the distance unit and the top level; no dependencies.
package npcm_pkg;

  localparam int ColorW    = 8;
  localparam int EntryW    = 3 * ColorW;
  localparam int CountW    = 5;
  localparam int EntryIdxW = 4;
  localparam int SquareW   = 2 * ColorW;
  localparam int WeightW   = 11;
  localparam int ProductW  = WeightW + SquareW;
  localparam int DistW     = 29;
  localparam int GreenShift = 11;

  localparam logic [WeightW-1:0] RedBase  = 11'd1024;
  localparam logic [WeightW-1:0] BlueBase = 11'd1534;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncMap   = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
  } npcm_tag_t;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } npcm_rgb_t;

endpackage

### hdl/npcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/npcm_dist.sv
// Three-stage pipelined redmean distance unit, shared by every palette entry.
// Depends on npcm_pkg.
module npcm_dist
  import npcm_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  npcm_tag_t        tag_i,
  input  logic [IDX_W-1:0] idx_i,
  input  npcm_rgb_t        pixel_i,
  input  npcm_rgb_t        entry_i,
  output npcm_tag_t        tag_o,
  output logic [IDX_W-1:0] idx_o,
  output npcm_rgb_t        entry_o,
  output logic [DistW-1:0] dist_o
);

  npcm_tag_t        tag1_q, tag2_q, tag3_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q;
  npcm_rgb_t        ent1_q, ent2_q, ent3_q;

  logic [ColorW-1:0]   dr, dg, db;
  logic [ColorW:0]     sum_red;
  logic [SquareW-1:0]  sqr_q, sqg_q, sqb_q;
  logic [ColorW:0]     s_q;
  logic [WeightW-1:0]  wr, wb;
  logic [ProductW-1:0] pr_q, pg_q, pb_q;
  logic [DistW-1:0]    dist_d, dist_q;

  assign dr = (pixel_i.red > entry_i.red) ? pixel_i.red - entry_i.red
                                          : entry_i.red - pixel_i.red;
  assign dg = (pixel_i.green > entry_i.green) ? pixel_i.green - entry_i.green
                                              : entry_i.green - pixel_i.green;
  assign db = (pixel_i.blue > entry_i.blue) ? pixel_i.blue - entry_i.blue
                                            : entry_i.blue - pixel_i.blue;
  assign sum_red = {1'b0, pixel_i.red} + {1'b0, entry_i.red};

  assign wr = RedBase + WeightW'(s_q);
  assign wb = BlueBase - WeightW'(s_q);

  assign dist_d = DistW'(pr_q) + DistW'(pg_q) + DistW'(pb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    ent1_q <= entry_i;
    sqr_q  <= SquareW'(dr * dr);
    sqg_q  <= SquareW'(dg * dg);
    sqb_q  <= SquareW'(db * db);
    s_q    <= sum_red;

    idx2_q <= idx1_q;
    ent2_q <= ent1_q;
    pr_q   <= ProductW'(wr * sqr_q);
    pg_q   <= ProductW'({sqg_q, {GreenShift{1'b0}}});
    pb_q   <= ProductW'(wb * sqb_q);

    idx3_q <= idx2_q;
    ent3_q <= ent2_q;
    dist_q <= dist_d;
  end

  assign tag_o   = tag3_q;
  assign idx_o   = idx3_q;
  assign entry_o = ent3_q;
  assign dist_o  = dist_q;

endmodule

### hdl/nearest_palette_color_mapper_top.sv
// Top level of the nearest palette color mapper: search sequencer, palette RAM,
// distance unit and output register. Depends on npcm_pkg, npcm_ram, npcm_dist.
//
// Channel  Dir  tdata bits (low first)                          tuser  tlast
// s_axis   in   entry_index[3:0] red[11:4] green[19:12]          func   end_of_frame
//               blue[27:20], zero pad to 32
// m_axis   out  red[7:0] green[15:8] blue[23:16] chosen_index     -      frame_done
//               [27:24] best_distance[56:28], zero pad to 64
// cfg      in   cfg_wdata_i = palette_count, written when cfg_we_i is high
//
// A pixel makes one RAM read per entry of the clamped palette count; the reads
// feed the three-stage distance unit, then the pipeline drains and the result
// moves to the output register.
// A new transaction is taken while a finished result waits on m_axis; a later
// result waits in the sequencer until the output register is free.
// Reset clears the sequencer and the valid flags; the palette RAM is not cleared.
module nearest_palette_color_mapper_top
  import npcm_pkg::*;
#(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // entry_index, in_red, in_green, in_blue
  input  logic                s_axis_tuser,   // func
  input  logic                s_axis_tlast,   // end_of_frame
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // out_red, out_green, out_blue,
                                              // chosen_index, best_distance
  output logic                m_axis_tlast    // frame_done
);

  localparam int IdxW   = $clog2(PALETTE_DEPTH);
  localparam int DepthW = $clog2(PALETTE_DEPTH + 1);
  localparam int CmpW   = (DepthW > CountW) ? DepthW : CountW;
  localparam int WrW    = (DepthW > EntryIdxW) ? DepthW : EntryIdxW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0] count_q;
  logic [IdxW-1:0]   last_q, last_d;
  logic [IdxW-1:0]   rd_q, rd_d;
  npcm_rgb_t         pixel_q;
  logic              eof_q;

  npcm_tag_t         iss_q, iss_d;
  logic [IdxW-1:0]   iss_idx_q;

  npcm_rgb_t         in_rgb;
  logic [EntryIdxW-1:0] in_idx;
  logic              in_acc;
  logic              wr_en;
  logic [WrW-1:0]    wr_ext;
  logic [CmpW-1:0]   cnt_ext;
  logic [CmpW-1:0]   depth_c;

  logic [EntryW-1:0] rdata;
  npcm_rgb_t         entry_rd;

  npcm_tag_t         dist_tag;
  logic [IdxW-1:0]   dist_idx;
  npcm_rgb_t         dist_ent;
  logic [DistW-1:0]  dist_val;

  logic [IdxW-1:0]   best_idx_q;
  npcm_rgb_t         best_ent_q;
  logic [DistW-1:0]  best_dist_q;
  logic              take_new;

  logic              out_valid_q;
  logic              out_load;
  npcm_rgb_t         out_ent_q;
  logic [EntryIdxW-1:0] out_idx_q;
  logic [DistW-1:0]  out_dist_q;
  logic              out_last_q;
  logic [WrW-1:0]    best_idx_ext;

  assign in_idx       = s_axis_tdata[3:0];
  assign in_rgb.red   = s_axis_tdata[11:4];
  assign in_rgb.green = s_axis_tdata[19:12];
  assign in_rgb.blue  = s_axis_tdata[27:20];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign wr_ext  = WrW'(in_idx);
  assign wr_en   = in_acc && (s_axis_tuser == FuncWrite) &&
                   (wr_ext < WrW'(PALETTE_DEPTH));
  assign cnt_ext = CmpW'(count_q);
  assign depth_c = CmpW'(PALETTE_DEPTH);

  always_comb begin
    if (cnt_ext == '0) begin
      last_d = '0;
    end else if (cnt_ext > depth_c) begin
      last_d = IdxW'(depth_c - CmpW'(1));
    end else begin
      last_d = IdxW'(cnt_ext - CmpW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  npcm_ram #(
    .WIDTH(EntryW),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(IdxW'(wr_ext)),
    .wdata_i(in_rgb),
    .re_i   (state_q == ST_SCAN),
    .raddr_i(rd_q),
    .rdata_o(rdata)
  );

  assign entry_rd = rdata;

  npcm_dist #(
    .IDX_W(IdxW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (iss_q),
    .idx_i  (iss_idx_q),
    .pixel_i(pixel_q),
    .entry_i(entry_rd),
    .tag_o  (dist_tag),
    .idx_o  (dist_idx),
    .entry_o(dist_ent),
    .dist_o (dist_val)
  );

  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    iss_d.valid = 1'b0;
    iss_d.last  = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_d = '0;
        if (in_acc && (s_axis_tuser == FuncMap)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        iss_d.valid = 1'b1;
        iss_d.last  = (rd_q == last_q);
        if (rd_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          rd_d = rd_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        if (dist_tag.valid && dist_tag.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_q        <= '0;
      iss_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      iss_q   <= iss_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign take_new = dist_tag.valid && ((dist_idx == '0) || (dist_val < best_dist_q));

  always_ff @(posedge clk_i) begin
    iss_idx_q <= rd_q;
    if (in_acc && (s_axis_tuser == FuncMap)) begin
      pixel_q <= in_rgb;
      eof_q   <= s_axis_tlast;
      last_q  <= last_d;
    end
    if (take_new) begin
      best_idx_q  <= dist_idx;
      best_ent_q  <= dist_ent;
      best_dist_q <= dist_val;
    end
    if (out_load) begin
      out_ent_q  <= best_ent_q;
      out_idx_q  <= best_idx_ext[EntryIdxW-1:0];
      out_dist_q <= best_dist_q;
      out_last_q <= eof_q;
    end
  end

  assign best_idx_ext = WrW'(best_idx_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'b0, out_dist_q, out_idx_q,
                          out_ent_q.blue, out_ent_q.green, out_ent_q.red};

  a_dist_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_tag.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("distance result outside a search");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_q <= last_q))
    else $error("scan address beyond palette count");

  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (best_idx_q <= last_q))
    else $error("chosen entry beyond palette count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (state_q != ST_IDLE || $past(state_q) != ST_DONE))
    else $error("result loaded over a pending transaction");

endmodule

### dv/tb_top.sv
// Self-checking testbench for nearest_palette_color_mapper_top: a directed table and
// random palette writes and pixel lookups checked against a redmean search predictor.
// Depends on npcm_pkg and the RTL of nearest_palette_color_mapper_top.
module tb_top
  import npcm_pkg::*;
();

  localparam int PaletteDepth = 16;
  localparam npcm_rgb_t Black = '0;
  localparam npcm_rgb_t White = '1;
  localparam logic [DistW-1:0] FarthestDist = 29'd299505150;
  localparam int PhaseItems = 40;
  localparam int SettleCycles = 30;

  typedef struct packed {
    logic                 func;
    logic [EntryIdxW-1:0] index;
    npcm_rgb_t            color;
    logic                 eof;
  } pixel_op_t;

  typedef struct packed {
    npcm_rgb_t            color;
    logic [EntryIdxW-1:0] index;
    logic [DistW-1:0]     distance;
    logic                 last;
  } match_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CountW-1:0] count;
    pixel_op_t         op;
    logic              has_want;
    match_t            want;
  } step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CountW-1:0]   cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [63:0]         m_axis_tdata;
  logic                m_axis_tlast;

  npcm_rgb_t         palette_copy [PaletteDepth];
  logic [CountW-1:0] count_setting;
  match_t            expected_matches [$];
  step_t             directed_steps [$];
  int                fault_count = 0;
  int                burst_left = 0;
  int                gap_left = 0;
  int                phase_counts [10] = '{16, 31, 0, 1, 17, 5, 2, 9, 16, 12};

  nearest_palette_color_mapper_top #(
    .PALETTE_DEPTH(PaletteDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [DistW-1:0] redmean_gap(npcm_rgb_t a, npcm_rgb_t b);
    longint unsigned s, dr, dg, db, d;
    s  = a.red + b.red;
    dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
    dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
    db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
    d  = (1024 + s) * dr * dr + 2048 * dg * dg + (1534 - s) * db * db;
    return d[DistW-1:0];
  endfunction

  function automatic match_t nearest_entry(pixel_op_t op);
    match_t           best;
    logic [DistW-1:0] d;
    int               n;
    n = (count_setting == 0) ? 1 :
        (count_setting > PaletteDepth) ? PaletteDepth : int'(count_setting);
    best.color    = palette_copy[0];
    best.index    = '0;
    best.distance = redmean_gap(op.color, palette_copy[0]);
    best.last     = op.eof;
    for (int p = 1; p < n; p++) begin
      d = redmean_gap(op.color, palette_copy[p]);
      if (d < best.distance) begin
        best.color    = palette_copy[p];
        best.index    = p[EntryIdxW-1:0];
        best.distance = d;
      end
    end
    return best;
  endfunction

  function automatic logic [ColorW-1:0] palette_level();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h80;
      2: return 8'hFF;
      default: return ColorW'($urandom);
    endcase
  endfunction

  function automatic step_t write_row(int idx, npcm_rgb_t color);
    step_t s;
    s = '0;
    s.op.func  = FuncWrite;
    s.op.index = idx[EntryIdxW-1:0];
    s.op.color = color;
    return s;
  endfunction

  function automatic step_t map_row(npcm_rgb_t color, logic eof);
    step_t s;
    s = '0;
    s.op.func  = FuncMap;
    s.op.index = EntryIdxW'($urandom);
    s.op.color = color;
    s.op.eof   = eof;
    return s;
  endfunction

  function automatic step_t map_row_want(npcm_rgb_t color, logic eof, npcm_rgb_t want_color,
                                         int want_idx, logic [DistW-1:0] want_dist);
    step_t s;
    s = map_row(color, eof);
    s.has_want      = 1'b1;
    s.want.color    = want_color;
    s.want.index    = want_idx[EntryIdxW-1:0];
    s.want.distance = want_dist;
    s.want.last     = eof;
    return s;
  endfunction

  function automatic step_t cfg_row(int count);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.count  = count[CountW-1:0];
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_op(input pixel_op_t op, input logic has_want, input match_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap_left != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_left) @(negedge clk_i);
      gap_left = 0;
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, op.color.blue, op.color.green, op.color.red, op.index};
    s_axis_tuser  <= op.func;
    s_axis_tlast  <= op.eof;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op.func == FuncWrite) begin
      palette_copy[op.index] = op.color;
    end else begin
      expected_matches.push_back(has_want ? want : nearest_entry(op));
    end
    @(negedge clk_i);
  endtask

  task automatic drain_matches();
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure_count(input int count);
    s_axis_tvalid <= 1'b0;
    drain_matches();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count[CountW-1:0];
    @(posedge clk_i);
    count_setting = count[CountW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    match_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_matches.size() == 0) begin
        $error("Unexpected result transaction, tdata %h", m_axis_tdata);
        fault_count++;
      end else begin
        want = expected_matches.pop_front();
        check_field("out_red", want.color.red, m_axis_tdata[7:0]);
        check_field("out_green", want.color.green, m_axis_tdata[15:8]);
        check_field("out_blue", want.color.blue, m_axis_tdata[23:16]);
        check_field("chosen_index", want.index, m_axis_tdata[27:24]);
        check_field("best_distance", want.distance, m_axis_tdata[56:28]);
        check_field("frame_done", want.last, m_axis_tlast);
      end
    end
  end

  initial begin : result_sink
    int mode;
    int left;
    mode = 0;
    left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 64);
      end
      left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= (left % 4 == 0);
        2: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (left < 4);
      endcase
    end
  end

  initial begin : stimulus
    pixel_op_t op;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    count_setting = 5'd1;
    foreach (palette_copy[i]) palette_copy[i] = '0;

    directed_steps.push_back(write_row(0, Black));
    directed_steps.push_back(map_row_want(Black, 1'b0, Black, 0, '0));
    directed_steps.push_back(map_row_want(White, 1'b1, Black, 0, FarthestDist));
    directed_steps.push_back(write_row(0, White));
    directed_steps.push_back(map_row_want(Black, 1'b0, White, 0, FarthestDist));
    directed_steps.push_back(write_row(15, Black));
    directed_steps.push_back(write_row(1, White));
    directed_steps.push_back(cfg_row(2));
    // Two identical entries: the lower index must win.
    directed_steps.push_back(map_row_want(White, 1'b1, White, 0, '0));
    directed_steps.push_back(map_row(24'h8040C0, 1'b0));
    directed_steps.push_back(write_row(1, Black));
    // A count of zero still searches entry zero.
    directed_steps.push_back(cfg_row(0));
    directed_steps.push_back(map_row_want(Black, 1'b0, White, 0, FarthestDist));
    directed_steps.push_back(cfg_row(2));
    directed_steps.push_back(map_row_want(Black, 1'b1, Black, 1, '0));
    directed_steps.push_back(write_row(2, 24'h123456));
    directed_steps.push_back(cfg_row(3));
    directed_steps.push_back(map_row(24'h133050, 1'b0));
    directed_steps.push_back(map_row(24'hFF0000, 1'b0));
    directed_steps.push_back(map_row(24'h00FF00, 1'b1));
    directed_steps.push_back(map_row(24'h0000FF, 1'b0));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        configure_count(directed_steps[i].count);
      end else begin
        send_op(directed_steps[i].op, directed_steps[i].has_want, directed_steps[i].want);
      end
    end

    // Every entry is written before any search can reach it.
    for (int e = 0; e < PaletteDepth; e++) begin
      op.func        = FuncWrite;
      op.index       = e[EntryIdxW-1:0];
      op.color.red   = palette_level();
      op.color.green = palette_level();
      op.color.blue  = palette_level();
      op.eof         = 1'($urandom_range(0, 1));
      send_op(op, 1'b0, '0);
    end

    foreach (phase_counts[ph]) begin
      configure_count(phase_counts[ph]);
      repeat (PhaseItems) begin
        op.index = EntryIdxW'($urandom);
        op.eof   = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 5) == 0) begin
          op.func = FuncWrite;
          op.color.red   = palette_level();
          op.color.green = palette_level();
          op.color.blue  = palette_level();
        end else begin
          op.func = FuncMap;
          if ($urandom_range(0, 3) == 0) begin
            op.color = palette_copy[$urandom_range(0, PaletteDepth - 1)];
          end else begin
            op.color.red   = palette_level();
            op.color.green = palette_level();
            op.color.blue  = palette_level();
          end
        end
        send_op(op, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    drain_matches();
    if (fault_count == 0 && expected_matches.size() == 0) begin
      $display("** nearest_palette_color_mapper_top: PASSED **");
    end else begin
      $display("** nearest_palette_color_mapper_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("** nearest_palette_color_mapper_top: FAILED **");
    $finish;
  end

endmodule
